[rtl/ap_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ap_pkg
// shared sizes, codes and controller/datapath interface types of the
// articulation point finder
// ----------------------------------------------------------------------------
package ap_pkg;

	localparam int MAX_NODES  = 256;
	localparam int NODE_W     = 8;    // node index
	localparam int NUM_W      = 9;    // node number / node count
	localparam int SLOT_COUNT = 2048;
	localparam int SLOT_W     = 11;   // slot index
	localparam int PTR_W      = 12;   // slot index or empty marker
	localparam int TIME_W     = 9;
	localparam int EXTRA_W    = 8;

	localparam logic [PTR_W-1:0] SLOT_NONE = PTR_W'(SLOT_COUNT);
	localparam logic [PTR_W-1:0] SLOT_FULL_AT = PTR_W'(SLOT_COUNT - 2);

	localparam logic [1:0] ACT_ADD   = 2'd0;
	localparam logic [1:0] ACT_RUN   = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_DISPATCH,
		OP_EDGE_RDA,
		OP_EDGE_WRA,
		OP_EDGE_RDB,
		OP_EDGE_WRB,
		OP_QRY_RD,
		OP_QRY_FIN,
		OP_CLEAR,
		OP_RUN_INIT,
		OP_ROOT_CHK,
		OP_ENTER_WAIT,
		OP_SLOT_RD,
		OP_SLOT_EVAL,
		OP_BACK_EVAL,
		OP_ROOT_POP,
		OP_POP_P,
		OP_POP_FIN,
		OP_POP_ADV,
		OP_RESP
	} ap_op_t;

	typedef struct packed {
		ap_op_t op;
		logic   take_in;
		logic   load_out;
	} ap_cmd_t;

	typedef struct packed {
		logic [1:0] act;
		logic       a_ok;
		logic       b_ok;
		logic       full;
		logic       top_none;
		logic       top_root;
		logic       root_done;
		logic       root_vis;
		logic       slot_pass;
		logic       slot_vis;
	} ap_stat_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [PTR_W-1:0]  cursor;
		logic [SLOT_W-1:0] entry;
		logic [TIME_W-1:0] low;
		logic [TIME_W-1:0] disc;
	} ap_frame_t;

endpackage

[rtl/ap_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ap_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module ap_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/ap_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ap_ctrl
// sequencer for edge loads, queries, clears and the depth-first walk
// ----------------------------------------------------------------------------
module ap_ctrl import ap_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  ap_stat_t stat,
	output ap_cmd_t  cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISPATCH,
		S_EDGE_RDA,
		S_EDGE_WRA,
		S_EDGE_RDB,
		S_EDGE_WRB,
		S_QRY_RD,
		S_QRY_FIN,
		S_CLEAR,
		S_RUN_INIT,
		S_ROOT_CHK,
		S_ENTER_WAIT,
		S_SLOT_RD,
		S_SLOT_EVAL,
		S_BACK_EVAL,
		S_ROOT_POP,
		S_POP_P,
		S_POP_FIN,
		S_POP_ADV,
		S_RESP
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   take_in;
	logic   load_out;

	assign in_ready  = (state_q == S_IDLE);
	assign take_in   = in_valid && in_ready;
	assign load_out  = (state_q == S_RESP) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.take_in  = take_in;
		cmd.load_out = load_out;
		case (state_q)
			S_IDLE:       cmd.op = OP_IDLE;
			S_DISPATCH:   cmd.op = OP_DISPATCH;
			S_EDGE_RDA:   cmd.op = OP_EDGE_RDA;
			S_EDGE_WRA:   cmd.op = OP_EDGE_WRA;
			S_EDGE_RDB:   cmd.op = OP_EDGE_RDB;
			S_EDGE_WRB:   cmd.op = OP_EDGE_WRB;
			S_QRY_RD:     cmd.op = OP_QRY_RD;
			S_QRY_FIN:    cmd.op = OP_QRY_FIN;
			S_CLEAR:      cmd.op = OP_CLEAR;
			S_RUN_INIT:   cmd.op = OP_RUN_INIT;
			S_ROOT_CHK:   cmd.op = OP_ROOT_CHK;
			S_ENTER_WAIT: cmd.op = OP_ENTER_WAIT;
			S_SLOT_RD:    cmd.op = OP_SLOT_RD;
			S_SLOT_EVAL:  cmd.op = OP_SLOT_EVAL;
			S_BACK_EVAL:  cmd.op = OP_BACK_EVAL;
			S_ROOT_POP:   cmd.op = OP_ROOT_POP;
			S_POP_P:      cmd.op = OP_POP_P;
			S_POP_FIN:    cmd.op = OP_POP_FIN;
			S_POP_ADV:    cmd.op = OP_POP_ADV;
			S_RESP:       cmd.op = OP_RESP;
			default:      cmd.op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (take_in) state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					case (stat.act)
						ACT_ADD: begin
							state_q <= (stat.a_ok && stat.b_ok && !stat.full) ? S_EDGE_RDA : S_RESP;
						end
						ACT_RUN:   state_q <= S_RUN_INIT;
						ACT_QUERY: state_q <= stat.a_ok ? S_QRY_RD : S_RESP;
						ACT_CLEAR: state_q <= S_CLEAR;
						default:   state_q <= S_RESP;
					endcase
				end
				S_EDGE_RDA:   state_q <= S_EDGE_WRA;
				S_EDGE_WRA:   state_q <= S_EDGE_RDB;
				S_EDGE_RDB:   state_q <= S_EDGE_WRB;
				S_EDGE_WRB:   state_q <= S_RESP;
				S_QRY_RD:     state_q <= S_QRY_FIN;
				S_QRY_FIN:    state_q <= S_RESP;
				S_CLEAR:      state_q <= S_RESP;
				S_RUN_INIT:   state_q <= S_ROOT_CHK;
				S_ROOT_CHK: begin
					if (stat.root_done) state_q <= S_RESP;
					else if (!stat.root_vis) state_q <= S_ENTER_WAIT;
				end
				S_ENTER_WAIT: state_q <= S_SLOT_RD;
				S_SLOT_RD: begin
					if (!stat.top_none) state_q <= S_SLOT_EVAL;
					else if (stat.top_root) state_q <= S_ROOT_POP;
					else state_q <= S_POP_P;
				end
				S_SLOT_EVAL: begin
					if (stat.slot_pass) state_q <= S_SLOT_RD;
					else if (stat.slot_vis) state_q <= S_BACK_EVAL;
					else state_q <= S_ENTER_WAIT;
				end
				S_BACK_EVAL:  state_q <= S_SLOT_RD;
				S_ROOT_POP:   state_q <= S_ROOT_CHK;
				S_POP_P:      state_q <= S_POP_FIN;
				S_POP_FIN:    state_q <= S_POP_ADV;
				S_POP_ADV:    state_q <= S_SLOT_RD;
				S_RESP: begin
					if (load_out) state_q <= S_IDLE;
				end
				default:      state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[rtl/ap_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ap_dpath
// adjacency store, search stack, per-node times and counts, result register
// ----------------------------------------------------------------------------
module ap_dpath import ap_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  ap_cmd_t            cmd,
	input  logic [NUM_W-1:0]   nodes_in_use,
	input  logic [1:0]         action,
	input  logic [NUM_W-1:0]   node_a,
	input  logic [NUM_W-1:0]   node_b,
	output ap_stat_t           stat,
	output logic [1:0]         status,
	output logic [NUM_W-1:0]   node,
	output logic [EXTRA_W-1:0] extra_components,
	output logic               is_cut_point,
	output logic [NUM_W-1:0]   cut_point_total
);

	// item and result
	logic [1:0]         act_q;
	logic [NUM_W-1:0]   a_q, b_q;
	logic [1:0]         res_status_q;
	logic [NUM_W-1:0]   res_node_q;
	logic [EXTRA_W-1:0] res_extra_q;
	logic [1:0]         out_status_q;
	logic [NUM_W-1:0]   out_node_q;
	logic [EXTRA_W-1:0] out_extra_q;
	logic               out_cut_q;
	logic [NUM_W-1:0]   out_total_q;

	// control state
	logic [PTR_W-1:0]     su_q;
	logic [NUM_W-1:0]     total_q;
	logic [TIME_W-1:0]    time_q;
	logic [NUM_W-1:0]     r_q;
	logic [NODE_W-1:0]    f_q;
	logic [MAX_NODES-1:0] head_valid_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [MAX_NODES-1:0] ev_q;

	// top frame
	logic [NODE_W-1:0] u_q;
	logic [PTR_W-1:0]  s_q;
	logic [SLOT_W-1:0] entry_q;
	logic [TIME_W-1:0] low_q;
	logic [TIME_W-1:0] disc_q;
	logic              bump_q;
	logic [PTR_W-1:0]  nxt_q;
	logic              hv_rd_q;
	logic              ev_rd_q;

	// memory ports
	logic [NODE_W-1:0]  head_raddr, head_waddr;
	logic [PTR_W-1:0]   head_wdata, head_rd;
	logic               head_we;
	logic               slot_we;
	logic [SLOT_W-1:0]  slot_waddr;
	logic [PTR_W-1:0]   nxt_rd;
	logic [NODE_W-1:0]  tgt_wdata, tgt_rd;
	logic               disc_we;
	logic [NODE_W-1:0]  disc_waddr;
	logic [TIME_W-1:0]  disc_rd;
	logic               ex_we;
	logic [NODE_W-1:0]  ex_raddr;
	logic [EXTRA_W-1:0] ex_wdata, ex_rd;
	logic               stk_we;
	ap_frame_t          stk_wdata, fr;

	logic [NODE_W-1:0]  ia, ib;
	logic [PTR_W-1:0]   su_p1;
	logic [PTR_W-1:0]   head_ptr;
	logic [EXTRA_W-1:0] ex_old;
	logic               skip;
	logic               root_enter, slot_enter;

	assign ia       = NODE_W'(a_q - NUM_W'(1));
	assign ib       = NODE_W'(b_q - NUM_W'(1));
	assign su_p1    = su_q + PTR_W'(1);
	assign head_ptr = hv_rd_q ? head_rd : SLOT_NONE;
	assign ex_old   = ev_rd_q ? ex_rd : '0;
	assign skip     = (f_q != '0) && (s_q[SLOT_W-1:0] == (entry_q ^ SLOT_W'(1)));

	always_comb begin
		stat.act       = act_q;
		stat.a_ok      = (a_q != '0) && (a_q <= nodes_in_use);
		stat.b_ok      = (b_q != '0) && (b_q <= nodes_in_use);
		stat.full      = su_q > SLOT_FULL_AT;
		stat.top_none  = s_q[PTR_W-1];
		stat.top_root  = (f_q == '0);
		stat.root_done = r_q >= nodes_in_use;
		stat.root_vis  = visited_q[r_q[NODE_W-1:0]];
		stat.slot_pass = skip || ({1'b0, tgt_rd} >= nodes_in_use);
		stat.slot_vis  = visited_q[tgt_rd];
	end

	assign root_enter = (cmd.op == OP_ROOT_CHK) && !stat.root_done && !stat.root_vis;
	assign slot_enter = (cmd.op == OP_SLOT_EVAL) && !stat.slot_pass && !stat.slot_vis;

	// read and write address selection
	always_comb begin
		case (cmd.op)
			OP_EDGE_RDA: head_raddr = ia;
			OP_EDGE_RDB: head_raddr = ib;
			OP_ROOT_CHK: head_raddr = r_q[NODE_W-1:0];
			default:     head_raddr = tgt_rd;
		endcase
		head_we    = (cmd.op == OP_EDGE_WRA) || (cmd.op == OP_EDGE_WRB);
		head_waddr = (cmd.op == OP_EDGE_WRB) ? ib : ia;
		head_wdata = (cmd.op == OP_EDGE_WRB) ? su_p1 : su_q;
		slot_we    = head_we;
		slot_waddr = (cmd.op == OP_EDGE_WRB) ? su_p1[SLOT_W-1:0] : su_q[SLOT_W-1:0];
		tgt_wdata  = (cmd.op == OP_EDGE_WRB) ? ia : ib;
		disc_we    = root_enter || slot_enter;
		disc_waddr = root_enter ? r_q[NODE_W-1:0] : tgt_rd;
		case (cmd.op)
			OP_QRY_RD: ex_raddr = ia;
			OP_POP_P:  ex_raddr = fr.node;
			default:   ex_raddr = u_q;
		endcase
		ex_we    = (cmd.op == OP_ROOT_POP) || ((cmd.op == OP_POP_FIN) && bump_q);
		if (cmd.op == OP_ROOT_POP) begin
			ex_wdata = (ex_old > EXTRA_W'(1)) ? ex_old - EXTRA_W'(1) : '0;
		end else begin
			ex_wdata = (ex_old == '1) ? ex_old : ex_old + EXTRA_W'(1);
		end
		stk_we           = slot_enter;
		stk_wdata.node   = u_q;
		stk_wdata.cursor = s_q;
		stk_wdata.entry  = entry_q;
		stk_wdata.low    = low_q;
		stk_wdata.disc   = disc_q;
	end

	ap_ram #(.WIDTH(PTR_W), .DEPTH(MAX_NODES)) u_head (
		.clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
		.raddr(head_raddr), .rdata(head_rd)
	);

	ap_ram #(.WIDTH(PTR_W), .DEPTH(SLOT_COUNT)) u_slot_next (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(head_ptr),
		.raddr(s_q[SLOT_W-1:0]), .rdata(nxt_rd)
	);

	ap_ram #(.WIDTH(NODE_W), .DEPTH(SLOT_COUNT)) u_slot_target (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(tgt_wdata),
		.raddr(s_q[SLOT_W-1:0]), .rdata(tgt_rd)
	);

	ap_ram #(.WIDTH(TIME_W), .DEPTH(MAX_NODES)) u_disc (
		.clk(clk), .we(disc_we), .waddr(disc_waddr), .wdata(time_q),
		.raddr(tgt_rd), .rdata(disc_rd)
	);

	ap_ram #(.WIDTH(EXTRA_W), .DEPTH(MAX_NODES)) u_extra (
		.clk(clk), .we(ex_we), .waddr(u_q), .wdata(ex_wdata),
		.raddr(ex_raddr), .rdata(ex_rd)
	);

	ap_ram #(.WIDTH($bits(ap_frame_t)), .DEPTH(MAX_NODES)) u_stack (
		.clk(clk), .we(stk_we), .waddr(f_q), .wdata(stk_wdata),
		.raddr(f_q - NODE_W'(1)), .rdata(fr)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			su_q         <= '0;
			total_q      <= '0;
			time_q       <= TIME_W'(1);
			r_q          <= '0;
			f_q          <= '0;
			head_valid_q <= '0;
			visited_q    <= '0;
			ev_q         <= '0;
		end else begin
			case (cmd.op)
				OP_EDGE_WRA: head_valid_q[ia] <= 1'b1;
				OP_EDGE_WRB: begin
					head_valid_q[ib] <= 1'b1;
					su_q             <= su_q + PTR_W'(2);
				end
				OP_CLEAR: begin
					head_valid_q <= '0;
					visited_q    <= '0;
					ev_q         <= '0;
					su_q         <= '0;
					total_q      <= '0;
				end
				OP_RUN_INIT: begin
					visited_q <= '0;
					ev_q      <= '0;
					time_q    <= TIME_W'(1);
					r_q       <= '0;
					total_q   <= '0;
				end
				OP_ROOT_CHK: begin
					if (!stat.root_done) begin
						if (stat.root_vis) begin
							r_q <= r_q + NUM_W'(1);
						end else begin
							visited_q[r_q[NODE_W-1:0]] <= 1'b1;
							time_q <= time_q + TIME_W'(1);
							f_q    <= '0;
						end
					end
				end
				OP_SLOT_EVAL: begin
					if (slot_enter) begin
						visited_q[tgt_rd] <= 1'b1;
						time_q <= time_q + TIME_W'(1);
						f_q    <= f_q + NODE_W'(1);
					end
				end
				OP_ROOT_POP: begin
					ev_q[u_q] <= 1'b1;
					if (ex_old > EXTRA_W'(1)) total_q <= total_q + NUM_W'(1);
					r_q <= r_q + NUM_W'(1);
				end
				OP_POP_P: f_q <= f_q - NODE_W'(1);
				OP_POP_FIN: begin
					if (bump_q) begin
						ev_q[u_q] <= 1'b1;
						// a non-root node turns into a cut point on its first count
						if ((ex_old == '0) && (f_q != '0)) total_q <= total_q + NUM_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		hv_rd_q <= head_valid_q[head_raddr];
		ev_rd_q <= ev_q[ex_raddr];
		if (cmd.take_in) begin
			act_q <= action;
			a_q   <= node_a;
			b_q   <= node_b;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			out_node_q   <= res_node_q;
			out_extra_q  <= res_extra_q;
			out_cut_q    <= (res_extra_q != '0);
			out_total_q  <= total_q;
		end
		case (cmd.op)
			OP_DISPATCH: begin
				res_node_q  <= '0;
				res_extra_q <= '0;
				if ((act_q == ACT_ADD) && (!stat.a_ok || !stat.b_ok)) begin
					res_status_q <= ST_RANGE;
				end else if ((act_q == ACT_ADD) && stat.full) begin
					res_status_q <= ST_FULL;
				end else if ((act_q == ACT_QUERY) && !stat.a_ok) begin
					res_status_q <= ST_RANGE;
				end else begin
					res_status_q <= ST_OK;
				end
			end
			OP_QRY_FIN: begin
				res_node_q  <= a_q;
				res_extra_q <= ex_old;
			end
			OP_ROOT_CHK: begin
				if (root_enter) begin
					u_q    <= r_q[NODE_W-1:0];
					low_q  <= time_q;
					disc_q <= time_q;
				end
			end
			OP_ENTER_WAIT: s_q <= head_ptr;
			OP_SLOT_EVAL: begin
				nxt_q <= nxt_rd;
				if (stat.slot_pass) begin
					s_q <= nxt_rd;
				end else if (slot_enter) begin
					u_q     <= tgt_rd;
					entry_q <= s_q[SLOT_W-1:0];
					low_q   <= time_q;
					disc_q  <= time_q;
				end
			end
			OP_BACK_EVAL: begin
				if (disc_rd < low_q) low_q <= disc_rd;
				s_q <= nxt_q;
			end
			OP_POP_P: begin
				u_q     <= fr.node;
				s_q     <= fr.cursor;
				entry_q <= fr.entry;
				disc_q  <= fr.disc;
				low_q   <= (low_q < fr.low) ? low_q : fr.low;
				bump_q  <= (f_q == NODE_W'(1)) || (low_q >= fr.disc);
			end
			OP_POP_ADV: s_q <= nxt_rd;
			default: ;
		endcase
	end

	assign status           = out_status_q;
	assign node             = out_node_q;
	assign extra_components = out_extra_q;
	assign is_cut_point     = out_cut_q;
	assign cut_point_total  = out_total_q;

endmodule

[rtl/articulation_point_finder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// articulation_point_finder_top
// add edge: head of node_a read and written, then head of node_b; query: extra
//   count read; refused add or query goes straight to the result beat
// run: walk from each unvisited root, entering nodes, scanning slots, testing
//   back edges and popping tree edges, through the stack and slot rams
// throughput: one item at a time; a new beat is taken while a result waits
// reset: asynchronous, clears graph, visit and count flags; node_count is 1
// ----------------------------------------------------------------------------
module articulation_point_finder_top import ap_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input beat
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // action[1:0], node_a[10:2], node_b[19:11]
	// result beat
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // status[1:0], node[10:2], extra_components[18:11],
	                              // is_cut_point[19], cut_point_total[28:20]
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [NUM_W-1:0]   node_count_q;
	logic [NUM_W-1:0]   nodes_in_use;
	ap_cmd_t            cmd;
	ap_stat_t           stat;
	logic [1:0]         status;
	logic [NUM_W-1:0]   node;
	logic [EXTRA_W-1:0] extra_components;
	logic               is_cut_point;
	logic [NUM_W-1:0]   cut_point_total;

	// node_count register at byte address 0, writes complete in the access phase
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{(32-NUM_W){1'b0}}, node_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NUM_W'(1);
		end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
			node_count_q <= pwdata[NUM_W-1:0];
		end
	end

	// counts above the node capacity act as the capacity
	assign nodes_in_use = (node_count_q > NUM_W'(MAX_NODES)) ? NUM_W'(MAX_NODES) : node_count_q;

	ap_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ap_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.nodes_in_use    (nodes_in_use),
		.action          (s_tdata[1:0]),
		.node_a          (s_tdata[10:2]),
		.node_b          (s_tdata[19:11]),
		.stat            (stat),
		.status          (status),
		.node            (node),
		.extra_components(extra_components),
		.is_cut_point    (is_cut_point),
		.cut_point_total (cut_point_total)
	);

	// result packing, upper bits zero
	assign m_tdata = {3'b000, cut_point_total, is_cut_point, extra_components, node, status};

endmodule
